// File: rtl/ovn_pkg.sv
// Package for the octave value noise core: field types, register indexes,
// hash constants and the cosine table entry function. No dependencies.
package ovn_pkg;

    localparam int OVN_MAX_OCTAVES    = 8;
    localparam int OVN_COS_TABLE_BITS = 8;
    localparam int OVN_FRACTION_BITS  = 16;

    typedef logic [31:0]        t_coord;
    typedef logic signed [20:0] t_noise;
    typedef logic signed [17:0] t_val;

    localparam logic [0:0] REG_PERSISTENCE  = 1'b0;
    localparam logic [0:0] REG_OCTAVE_COUNT = 1'b1;

    localparam logic [16:0] PERS_RESET = 17'd32768;
    localparam logic [3:0]  OCT_RESET  = 4'd4;
    localparam logic [16:0] NOISE_ONE  = 17'd65536;

    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_A = 32'd789221;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

    localparam logic signed [23:0] OUT_MAX = 24'sd524288;
    localparam logic signed [23:0] OUT_MIN = -24'sd524288;

    // (1 - cos(pi k / 2^bits)) / 2 in Q.16, via sin^2 from a Q30 series
    function automatic logic [16:0] cos_entry(input int unsigned k, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] r;
        x  = (64'd1686629713 * 64'(k)) >> bits;
        x2 = (x * x) >> 30;
        h  = 64'd1073741824;
        for (int j = 0; j < 6; j++) begin
            t = (x2 * h) >> 30;
            case (j)
                0:       t = t / 156;
                1:       t = t / 110;
                2:       t = t / 72;
                3:       t = t / 42;
                4:       t = t / 20;
                default: t = t / 6;
            endcase
            h = 64'd1073741824 - t;
        end
        s = (x * h) >> 30;
        if (s > 64'd1073741824) begin
            s = 64'd1073741824;
        end
        s2 = (s * s) >> 30;
        r  = (s2 + 64'd8192) >> 14;
        return r[16:0];
    endfunction

endpackage

// File: rtl/ovn_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on ovn_pkg for the field types.
interface ovn_in_if;
    import ovn_pkg::*;
    logic   valid;
    logic   ready;
    t_coord coord_x;
    t_coord coord_y;
    modport source (output valid, coord_x, coord_y, input ready);
    modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

interface ovn_out_if;
    import ovn_pkg::*;
    logic   valid;
    logic   ready;
    t_noise noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// File: rtl/ovn_cos_rom.sv
// Constant cosine-easing table, indexed by the top bits of a fraction.
// Depends on ovn_pkg::cos_entry.
module ovn_cos_rom #(
    parameter int COS_TABLE_BITS = ovn_pkg::OVN_COS_TABLE_BITS,
    parameter int FRACTION_BITS  = ovn_pkg::OVN_FRACTION_BITS
) (
    input  logic [FRACTION_BITS-1:0] i_frac,
    output logic [16:0]              o_weight
);
    import ovn_pkg::*;

    localparam int N = 1 << COS_TABLE_BITS;

    logic [16:0]               w_rom [N];
    logic [COS_TABLE_BITS-1:0] w_idx;

    for (genvar k = 0; k < N; k++) begin : g_rom
        localparam logic [16:0] ENTRY = cos_entry(k, COS_TABLE_BITS);
        assign w_rom[k] = ENTRY;
    end

    if (FRACTION_BITS >= COS_TABLE_BITS) begin : g_hi
        assign w_idx = i_frac[FRACTION_BITS-1 -: COS_TABLE_BITS];
    end else begin : g_lo
        assign w_idx = {i_frac, {(COS_TABLE_BITS-FRACTION_BITS){1'b0}}};
    end

    assign o_weight = w_rom[w_idx];

endmodule

// File: rtl/octave_value_noise_2d_core.sv
// Top level of the 2D octave value noise core: APB registers, sequencer and
// one shared 33x33 multiplier. Depends on ovn_pkg, ovn_if.sv, ovn_cos_rom.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+---------------------------------
//  i_req     | in  | valid / ready   | coord_x, coord_y (Q16.16)
//  o_res     | out | valid / ready   | noise_value (signed Q4.16)
//  APB       | in  | psel/penable    | persistence, octave_count
//
// One request per pass; each octave runs 16 lattice hashes on the shared
// multiplier, 36 smoothing taps, then the blend, term and amplitude steps,
// with an entry step before the first octave and an exit step after the last.
// Reset (synchronous, active low) returns the sequencer to idle and loads
// the register defaults. The result waits in an output register, so a new
// request is taken while the previous result stalls; the pass then holds in
// its final state until the output register frees up.
module octave_value_noise_2d_core #(
    parameter int MAX_OCTAVES    = ovn_pkg::OVN_MAX_OCTAVES,
    parameter int COS_TABLE_BITS = ovn_pkg::OVN_COS_TABLE_BITS,
    parameter int FRACTION_BITS  = ovn_pkg::OVN_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ovn_in_if.sink      i_req,
    ovn_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ovn_pkg::*;

    localparam int SXW = FRACTION_BITS + 32;
    localparam int CW  = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_HASH   = 7'b0000010,
        S_SMOOTH = 7'b0000100,
        S_BLEND  = 7'b0001000,
        S_TERM   = 7'b0010000,
        S_AMP    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    // ---------------- configuration registers ----------------
    logic [16:0] r_pers;
    logic [3:0]  r_oct;
    logic        w_wr;
    logic [0:0]  w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[2:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pers <= PERS_RESET;
            r_oct  <= OCT_RESET;
        end else if (w_wr) begin
            unique case (w_ridx)
                REG_PERSISTENCE:  r_pers <= pwdata[16:0];
                REG_OCTAVE_COUNT: r_oct  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            REG_PERSISTENCE:  prdata = {15'd0, r_pers};
            REG_OCTAVE_COUNT: prdata = {28'd0, r_oct};
            default:          prdata = '0;
        endcase
    end

    // ---------------- datapath state ----------------
    t_state                r_state;
    logic [SXW-1:0]        r_sx, r_sy;
    logic [CW-1:0]         r_left;
    logic [16:0]           r_amp;
    logic signed [23:0]    r_total;
    logic [16:0]           r_fx, r_fy;
    logic [3:0]            r_pt;
    logic [2:0]            r_step;
    logic [31:0]           r_n;
    logic signed [65:0]    r_prod;
    t_val                  r_lat [16];
    logic signed [21:0]    r_acc;
    logic [1:0]            r_corner;
    logic [1:0]            r_dx, r_dy;
    t_val                  r_v [4];
    t_val                  r_b1, r_b2, r_r;
    logic                  r_ovalid;
    t_noise                r_onoise;

    logic [16:0]           w_fx, w_fy;
    logic [16:0]           w_pers;
    logic [CW-1:0]         w_count;
    logic [31:0]           w_ix, w_iy, w_px, w_py, w_n0, w_n;
    logic [31:0]           w_t;
    t_val                  w_lat;
    logic signed [32:0]    w_ma, w_mb;
    logic signed [18:0]    w_shr;
    t_val                  w_tap;
    logic signed [21:0]    w_tapw, w_acc_next;
    logic [1:0]            w_sel_x, w_sel_y;
    logic signed [23:0]    w_sat;
    logic                  w_out_free;

    ovn_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_rom_x (
        .i_frac   (r_sx[FRACTION_BITS-1:0]),
        .o_weight (w_fx)
    );
    ovn_cos_rom #(.COS_TABLE_BITS(COS_TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_rom_y (
        .i_frac   (r_sy[FRACTION_BITS-1:0]),
        .o_weight (w_fy)
    );

    assign w_pers  = (r_pers > NOISE_ONE) ? NOISE_ONE : r_pers;
    assign w_count = ({1'b0, r_oct} > 5'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(r_oct);

    // lattice point of the 4x4 grid around the cell, wrapping at 32 bits
    assign w_ix = r_sx[FRACTION_BITS +: 32];
    assign w_iy = r_sy[FRACTION_BITS +: 32];
    assign w_px = w_ix + 32'(r_pt[1:0]) - 32'd1;
    assign w_py = w_iy + 32'(r_pt[3:2]) - 32'd1;
    assign w_n0 = w_px + (w_py << 6) - (w_py << 3) + w_py;   // x + 57y
    assign w_n  = (w_n0 << 13) ^ w_n0;

    assign w_t   = (r_prod[31:0] + HASH_ADD_B) & 32'h7fffffff;
    assign w_lat = t_val'(18'sd65536 - $signed({1'b0, w_t[30:14]}));

    // floor of product / 65536
    assign w_shr = r_prod[34:16];

    // smoothing tap: corner weight 1, side 2, center 4
    assign w_sel_x = r_corner[0] + r_dx;
    assign w_sel_y = r_corner[1] + r_dy;
    assign w_tap   = r_lat[{w_sel_y, w_sel_x}];
    always_comb begin
        case (2'(r_dx == 2'd1) + 2'(r_dy == 2'd1))
            2'd0:    w_tapw = 22'(w_tap);
            2'd1:    w_tapw = 22'(w_tap) <<< 1;
            default: w_tapw = 22'(w_tap) <<< 2;
        endcase
    end
    assign w_acc_next = r_acc + w_tapw;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_HASH: begin
                case (r_step)
                    3'd1: begin
                        w_ma = {1'b0, r_n};
                        w_mb = {1'b0, r_n};
                    end
                    3'd2: begin
                        w_ma = {1'b0, r_prod[31:0]};
                        w_mb = {1'b0, HASH_MUL_A};
                    end
                    3'd3: begin
                        w_ma = {1'b0, r_n};
                        w_mb = {1'b0, r_prod[31:0] + HASH_ADD_A};
                    end
                    default: ;
                endcase
            end
            S_BLEND: begin
                case (r_step)
                    3'd0: begin
                        w_ma = 33'(r_v[1]) - 33'(r_v[0]);
                        w_mb = {16'd0, r_fx};
                    end
                    3'd1: begin
                        w_ma = 33'(r_v[3]) - 33'(r_v[2]);
                        w_mb = {16'd0, r_fx};
                    end
                    3'd3: begin
                        w_ma = 33'(r_b2) - 33'(r_b1);
                        w_mb = {16'd0, r_fy};
                    end
                    default: ;
                endcase
            end
            S_TERM: begin
                w_ma = 33'(r_r);
                w_mb = {16'd0, r_amp};
            end
            S_AMP: begin
                w_ma = {16'd0, r_amp};
                w_mb = {16'd0, w_pers};
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_total > OUT_MAX) begin
            w_sat = OUT_MAX;
        end else if (r_total < OUT_MIN) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = r_total;
        end
    end

    assign w_out_free  = !r_ovalid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.noise_value = r_onoise;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_fx   <= w_fx;
        r_fy   <= w_fy;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_pt     <= '0;
            r_corner <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_left   <= '0;
        end else begin
            // result register: loaded from the final state, freed on accept
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_sx    <= SXW'(i_req.coord_x);
                        r_sy    <= SXW'(i_req.coord_y);
                        r_left  <= w_count;
                        r_amp   <= NOISE_ONE;
                        r_total <= '0;
                        r_pt    <= '0;
                        r_step  <= '0;
                        r_state <= (w_count == '0) ? S_FIN : S_HASH;
                    end
                end
                S_HASH: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd0) begin
                        r_n <= w_n;
                    end
                    if (r_step == 3'd4) begin
                        r_lat[r_pt] <= w_lat;
                        r_step      <= '0;
                        r_pt        <= r_pt + 4'd1;
                        if (r_pt == 4'd15) begin
                            r_state  <= S_SMOOTH;
                            r_acc    <= '0;
                            r_corner <= '0;
                            r_dx     <= '0;
                            r_dy     <= '0;
                        end
                    end
                end
                S_SMOOTH: begin
                    if (r_dx == 2'd2) begin
                        r_dx <= '0;
                        if (r_dy == 2'd2) begin
                            r_dy             <= '0;
                            r_v[r_corner]    <= w_acc_next[21:4];
                            r_acc            <= '0;
                            r_corner         <= r_corner + 2'd1;
                            if (r_corner == 2'd3) begin
                                r_state <= S_BLEND;
                                r_step  <= '0;
                            end
                        end else begin
                            r_dy  <= r_dy + 2'd1;
                            r_acc <= w_acc_next;
                        end
                    end else begin
                        r_dx  <= r_dx + 2'd1;
                        r_acc <= w_acc_next;
                    end
                end
                S_BLEND: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_b1 <= t_val'(19'(r_v[0]) + w_shr);
                        3'd2: r_b2 <= t_val'(19'(r_v[2]) + w_shr);
                        3'd4: begin
                            r_r     <= t_val'(19'(r_b1) + w_shr);
                            r_step  <= '0;
                            r_state <= S_TERM;
                        end
                        default: ;
                    endcase
                end
                S_TERM: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_total <= r_total + 24'(w_shr);
                        r_step  <= '0;
                        r_state <= S_AMP;
                    end
                end
                S_AMP: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_amp  <= r_prod[32:16];
                        r_sx   <= r_sx << 1;
                        r_sy   <= r_sy << 1;
                        r_left <= r_left - CW'(1);
                        r_step <= '0;
                        r_pt   <= '0;
                        r_state <= (r_left == CW'(1)) ? S_FIN : S_HASH;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_onoise <= t_noise'(w_sat);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- checks ----------------
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.noise_value <= 21'sd524288 &&
                         o_res.noise_value >= -21'sd524288))
        else $error("noise result out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while a pass is running");

    a_amp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM) |-> (r_amp <= NOISE_ONE))
        else $error("octave amplitude above one");

    a_octaves_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH || r_state == S_AMP) |-> (r_left != '0))
        else $error("octave pass with no octaves left");

endmodule
